[design/swmms_pkg.sv]
// Shared constants and types for the sliding window min/max sum block.
package swmms_pkg;

	// Default build sizes
	localparam int MAX_WINDOW_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 16;

	// Fixed field widths
	localparam int SUM_BITS = 48;
	localparam int CFG_BITS = 7;

	// Window size after reset
	localparam logic [CFG_BITS-1:0] WINDOW_RESET = 7'd3;

	// Control that travels with an item down the pipeline
	typedef struct packed {
		logic valid;
		logic last;
		logic filled;
	} ctl_t;

endpackage

[design/sliding_window_min_max_sum.sv]
// Top level: sliding window min/max over a sample stream, summed per stream.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+--------------------------------
//   sample   | sample_valid / sample_stall  | sample, last
//   result   | result_valid / result_stall  | total, short_stream, saturated
//   config   | cfg_valid / cfg_ready        | window_size
//
// One sample is taken every cycle while the result register is free; a stalled
// result stalls the sample channel in the same cycle.
// After the edge that accepts its last sample, a result passes these registers: chain cell
// with stage 1 control, tap select, accumulator. Cell j holds the min and max of the
// j+1 newest samples; the tap grows by one per sample up to the window size minus one.
// Reset sets window_size to 3 and clears position, span, sum and pipeline valids.
module sliding_window_min_max_sum #(
	parameter int MAX_WINDOW  = swmms_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = swmms_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  sample_valid,
	output logic                                  sample_stall,
	input  logic signed [SAMPLE_BITS-1:0]         sample,
	input  logic                                  last,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic signed [swmms_pkg::SUM_BITS-1:0] total,
	output logic                                  short_stream,
	output logic                                  saturated,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [swmms_pkg::CFG_BITS-1:0]        window_size
);

	localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

	logic [swmms_pkg::CFG_BITS-1:0]   window_size_q;
	logic [31:0]                      pos_q;
	logic [IDX_W:0]                   span_q;
	logic [IDX_W-1:0]                 lim;
	logic [IDX_W-1:0]                 tap;
	logic [IDX_W-1:0]                 tap_s1;
	logic                             hold;
	logic                             adv;
	logic                             in_acc;
	swmms_pkg::ctl_t                  ctl_s1;
	swmms_pkg::ctl_t                  ctl_s2;
	logic signed [SAMPLE_BITS-1:0]    min_s2;
	logic signed [SAMPLE_BITS-1:0]    max_s2;
	logic signed [SAMPLE_BITS-1:0]    min_c [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0]    max_c [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0]    prev_min [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0]    prev_max [MAX_WINDOW];

	// Flow control: everything moves unless a result waits
	assign hold = result_valid && result_stall;
	assign adv = !hold;
	assign sample_stall = hold;
	assign in_acc = sample_valid && !sample_stall;
	assign cfg_ready = 1'b1;

	// Window size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= swmms_pkg::WINDOW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			window_size_q <= window_size;
		end
	end

	// Clamp the window to 1..MAX_WINDOW and take the cell index of its oldest sample
	always_comb begin
		if (window_size_q == '0) begin
			lim = '0;
		end else if (32'(window_size_q) > 32'(MAX_WINDOW)) begin
			lim = IDX_W'(MAX_WINDOW - 1);
		end else begin
			lim = IDX_W'(window_size_q - 7'd1);
		end
	end

	// Limit the tap to the samples still in the window; a grown window refills one
	// sample at a time
	always_comb begin
		if (span_q > {1'b0, lim}) begin
			tap = lim;
		end else begin
			tap = span_q[IDX_W-1:0];
		end
	end

	// Stream position; restart after the last sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (in_acc) begin
			pos_q <= last ? '0 : pos_q + 32'd1;
		end
	end

	// Samples in the window before the next one; restart after the last sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q <= '0;
		end else if (in_acc) begin
			span_q <= last ? '0 : {1'b0, tap} + 1'b1;
		end
	end

	// Chain of cells, each folding the new sample into its neighbor's extremes
	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign prev_min[i] = sample;
			assign prev_max[i] = sample;
		end else begin : g_link
			assign prev_min[i] = min_c[i-1];
			assign prev_max[i] = max_c[i-1];
		end
		swmms_cell #(
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_cell (
			.clk      (clk),
			.en       (in_acc),
			.smp      (sample),
			.prev_min (prev_min[i]),
			.prev_max (prev_max[i]),
			.cur_min  (min_c[i]),
			.cur_max  (max_c[i])
		);
	end

	// Stage 1 control: window is full once the position reaches the window size minus one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			tap_s1 <= '0;
		end else if (adv) begin
			ctl_s1.valid <= in_acc;
			ctl_s1.last <= last;
			ctl_s1.filled <= pos_q >= 32'(lim);
			tap_s1 <= tap;
		end
	end

	// Stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_s1;
		end
	end

	// Stage 2: pick the window extremes from the tap cell
	always_ff @(posedge clk) begin
		if (adv) begin
			min_s2 <= min_c[tap_s1];
			max_s2 <= max_c[tap_s1];
		end
	end

	swmms_acc #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.ctl_s2    (ctl_s2),
		.min_s2    (min_s2),
		.max_s2    (max_s2),
		.res_valid (result_valid),
		.res_total (total),
		.res_short (short_stream),
		.res_sat   (saturated)
	);

`ifndef SYNTHESIS
	// A new result transaction only follows a last sample leaving stage 2
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(ctl_s2.valid && ctl_s2.last))
		else $error("result without a last sample");

	// A short stream reports zero sum and no clipping
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && short_stream |-> total == '0 && !saturated)
		else $error("short stream result carries sum or clip");

	// The position restarts after an accepted last sample
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && last |=> pos_q == '0)
		else $error("position not cleared after last sample");
`endif

endmodule

[design/swmms_cell.sv]
// One cell of the running min/max chain.
module swmms_cell #(
	parameter int SAMPLE_BITS = swmms_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [SAMPLE_BITS-1:0] smp,
	input  logic signed [SAMPLE_BITS-1:0] prev_min,
	input  logic signed [SAMPLE_BITS-1:0] prev_max,
	output logic signed [SAMPLE_BITS-1:0] cur_min,
	output logic signed [SAMPLE_BITS-1:0] cur_max
);

	logic signed [SAMPLE_BITS-1:0] min_q;
	logic signed [SAMPLE_BITS-1:0] max_q;

	// Fold the new sample into the neighbor's extremes and take them over
	always_ff @(posedge clk) begin
		if (en) begin
			min_q <= (prev_min < smp) ? prev_min : smp;
			max_q <= (prev_max > smp) ? prev_max : smp;
		end
	end

	assign cur_min = min_q;
	assign cur_max = max_q;

endmodule

[design/swmms_acc.sv]
// Saturating accumulator and result register.
module swmms_acc #(
	parameter int SAMPLE_BITS = swmms_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   adv,
	input  swmms_pkg::ctl_t                        ctl_s2,
	input  logic signed [SAMPLE_BITS-1:0]          min_s2,
	input  logic signed [SAMPLE_BITS-1:0]          max_s2,
	output logic                                   res_valid,
	output logic signed [swmms_pkg::SUM_BITS-1:0]  res_total,
	output logic                                   res_short,
	output logic                                   res_sat
);

	localparam int SW = swmms_pkg::SUM_BITS;

	logic signed [SW-1:0]          sum_q;
	logic                          clip_q;
	logic                          out_valid_q;
	logic signed [SW-1:0]          total_q;
	logic                          short_q;
	logic                          sat_q;
	logic signed [SAMPLE_BITS:0]   pair;
	logic signed [SW:0]            wide;
	logic signed [SW-1:0]          sum_nxt;
	logic                          clip_nxt;
	logic                          ovf;

	// Add window min plus max and clip at the sum range
	always_comb begin
		pair = $signed({min_s2[SAMPLE_BITS-1], min_s2})
			+ $signed({max_s2[SAMPLE_BITS-1], max_s2});
		wide = $signed({sum_q[SW-1], sum_q})
			+ $signed({{(SW - SAMPLE_BITS){pair[SAMPLE_BITS]}}, pair});
		ovf = wide[SW] != wide[SW-1];
		sum_nxt = sum_q;
		clip_nxt = clip_q;
		if (ctl_s2.filled) begin
			if (ovf) begin
				sum_nxt = wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
				clip_nxt = 1'b1;
			end else begin
				sum_nxt = wide[SW-1:0];
			end
		end
	end

	// Hold the stream sum; drop it after the last sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			clip_q <= 1'b0;
		end else if (adv && ctl_s2.valid) begin
			if (ctl_s2.last) begin
				sum_q <= '0;
				clip_q <= 1'b0;
			end else begin
				sum_q <= sum_nxt;
				clip_q <= clip_nxt;
			end
		end
	end

	// Result transaction valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= ctl_s2.valid && ctl_s2.last;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (adv && ctl_s2.valid && ctl_s2.last) begin
			if (ctl_s2.filled) begin
				total_q <= sum_nxt;
				short_q <= 1'b0;
				sat_q <= clip_nxt;
			end else begin
				total_q <= '0;
				short_q <= 1'b1;
				sat_q <= 1'b0;
			end
		end
	end

	assign res_valid = out_valid_q;
	assign res_total = total_q;
	assign res_short = short_q;
	assign res_sat = sat_q;

endmodule

[tb/sliding_window_min_max_sum_tb.sv]
// Testbench for the sliding window min/max sum block: scoreboard, stimulus and checks.
`timescale 1ns / 100ps

module sliding_window_min_max_sum_tb;

	localparam int SB           = swmms_pkg::SAMPLE_BITS_DEF;
	localparam int WMAX         = swmms_pkg::MAX_WINDOW_DEF;
	localparam int SUM_BITS     = swmms_pkg::SUM_BITS;
	localparam int CFG_BITS     = swmms_pkg::CFG_BITS;
	localparam int ITEMS        = 1300;
	localparam int SETTLE_TICKS = 8;
	localparam int TIMEOUT_NS   = 5_000_000;

	typedef enum {SHAPE_NOISE, SHAPE_RISE, SHAPE_FALL, SHAPE_FLAT} shape_t;

	// Tracks stream state per accepted sample and holds the stream totals still due.
	class minmax_sum_tracker_t;
		localparam longint SUM_TOP    = (longint'(1) << 47) - 1;
		localparam longint SUM_BOTTOM = -SUM_TOP - 1;

		typedef struct {
			int unsigned tag;
			longint      value;
		} cand_t;

		typedef struct {
			logic signed [SUM_BITS-1:0] total;
			logic                       too_short;
			logic                       sat;
		} stream_total_t;

		logic [CFG_BITS-1:0] window_reg;
		cand_t               low_cands[$];
		cand_t               high_cands[$];
		int unsigned         position;
		bit                  filled;
		longint              sum;
		bit                  clipped;
		stream_total_t       totals_due[$];
		int                  fails;
		int                  checked;
		int                  shorts;

		function new();
			window_reg = swmms_pkg::WINDOW_RESET;
			fails = 0;
			checked = 0;
			shorts = 0;
			clear_stream();
		endfunction

		function void clear_stream();
			low_cands.delete();
			high_cands.delete();
			position = 0;
			filled = 0;
			sum = 0;
			clipped = 0;
		endfunction

		function void set_window(logic [CFG_BITS-1:0] v);
			window_reg = v;
		endfunction

		// Clamp the register into 1..MAX_WINDOW.
		function int unsigned span();
			if (window_reg == 0)
				return 1;
			if (window_reg > WMAX)
				return WMAX;
			return 32'(window_reg);
		endfunction

		function int pending();
			return totals_due.size();
		endfunction

		// Drop expired entries at the front, dominated ones at the back, then push.
		function void slide(ref cand_t q[$], input longint v, input int unsigned k,
			input bit keep_low);
			while (q.size() > 0 && (position - q[0].tag) >= k)
				q.delete(0);
			while (q.size() > 0 && (keep_low ? q[$].value >= v : q[$].value <= v))
				q.delete(q.size() - 1);
			if (q.size() >= WMAX)
				q.delete(0);
			q.insert(q.size(), cand_t'{position, v});
		endfunction

		function void take_sample(logic signed [SB-1:0] s, bit is_last);
			longint        v;
			int unsigned   k;
			int unsigned   age;
			longint        acc;
			stream_total_t res;
			v = longint'(s);
			k = span();
			age = position;
			slide(low_cands, v, k, 1'b1);
			slide(high_cands, v, k, 1'b0);
			if (!filled && longint'(age) + 1 >= k)
				filled = 1;
			if (filled && longint'(age) + 1 < k && age < WMAX)
				filled = 0;
			// Accumulate min plus max of a full window, clipping at the sum range
			if (filled) begin
				acc = sum + low_cands[0].value + high_cands[0].value;
				if (acc > SUM_TOP) begin
					acc = SUM_TOP;
					clipped = 1;
				end else if (acc < SUM_BOTTOM) begin
					acc = SUM_BOTTOM;
					clipped = 1;
				end
				sum = acc;
			end
			position++;
			if (!is_last)
				return;
			if (filled) begin
				res.total = sum[SUM_BITS-1:0];
				res.too_short = 0;
				res.sat = clipped;
			end else begin
				res.total = '0;
				res.too_short = 1;
				res.sat = 0;
			end
			totals_due.insert(totals_due.size(), res);
			clear_stream();
		endfunction

		function void report(string msg);
			if (fails < 10)
				$display("%0t mismatch: %s", $time, msg);
			fails++;
		endfunction

		function void check_result(logic signed [SUM_BITS-1:0] t, logic sf, logic sat);
			stream_total_t exp;
			if (totals_due.size() == 0) begin
				report($sformatf("result with no stream pending: total %0d short %b sat %b",
					t, sf, sat));
				return;
			end
			exp = totals_due[0];
			totals_due.delete(0);
			checked++;
			if (exp.too_short)
				shorts++;
			if (t !== exp.total || sf !== exp.too_short || sat !== exp.sat)
				report($sformatf("total %0d/%0d short %b/%b sat %b/%b (expected/actual)",
					exp.total, t, exp.too_short, sf, exp.sat, sat));
		endfunction

		function void finish_check();
			if (totals_due.size() != 0)
				report($sformatf("%0d stream totals never arrived", totals_due.size()));
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       sample_valid;
	logic                       sample_stall;
	logic signed [SB-1:0]       sample;
	logic                       last;
	logic                       result_valid;
	logic                       result_stall;
	logic signed [SUM_BITS-1:0] total;
	logic                       short_stream;
	logic                       saturated;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_BITS-1:0]        window_size;

	minmax_sum_tracker_t tracker;
	bit                  calm;
	int                  sent;
	int                  cfg_writes;
	int                  mid_changes;

	sliding_window_min_max_sum dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.last         (last),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.total        (total),
		.short_stream (short_stream),
		.saturated    (saturated),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.window_size  (window_size)
	);

	// Clock
	always #4 clk = ~clk;

	// Check every result transaction against the oldest stream total due
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			tracker.check_result(total, short_stream, saturated);
	end

	// Stall the result side a random number of cycles ahead of each transaction
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			n = calm ? 0 : $urandom_range(0, 5);
			if (n > 0) begin
				result_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!(result_valid && !result_stall));
		end
	end

	// Bound the run
	initial begin
		#(TIMEOUT_NS);
		$display("timeout after %0d samples, %0d streams checked", sent, tracker.checked);
		$display("[sliding_window_min_max_sum] ERROR");
		$finish;
	end

	task automatic send_sample(input logic signed [SB-1:0] value, input bit is_last);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 5);
		@(negedge clk);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid <= 1'b1;
		sample <= value;
		last <= is_last;
		do @(posedge clk); while (sample_stall);
		tracker.take_sample(value, is_last);
		sent++;
	endtask

	// Drop valid, wait for every pending total, then let the pipeline drain.
	task automatic settle();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic write_window(input logic [CFG_BITS-1:0] v);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		window_size <= v;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_window(v);
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [SB-1:0] draw_value(shape_t shape,
		logic signed [SB-1:0] base, int idx, int step);
		int r;
		r = $urandom_range(0, 9);
		case (shape)
			SHAPE_RISE: return SB'(base + idx * step);
			SHAPE_FALL: return SB'(base - idx * step);
			SHAPE_FLAT: return base;
			default: begin
				if (r == 0)
					return SB'(-32768);
				if (r == 1)
					return SB'(32767);
				if (r == 2)
					return $urandom_range(0, 1) ? SB'(0) : SB'(-1);
				if (r == 3)
					return SB'(int'($urandom_range(0, 40)) - 20);
				return SB'($urandom);
			end
		endcase
	endfunction

	// Send one stream; optionally change the window partway through it.
	task automatic run_stream(input int len, input int change_at,
		input logic [CFG_BITS-1:0] new_win);
		shape_t               shape;
		logic signed [SB-1:0] base;
		int                   step;
		int                   r;
		r = $urandom_range(0, 5);
		shape = (r < 3) ? SHAPE_NOISE : shape_t'(r - 2);
		base = SB'($urandom);
		step = $urandom_range(1, 300);
		for (int i = 0; i < len; i++) begin
			if (i == change_at) begin
				write_window(new_win);
				mid_changes++;
			end
			send_sample(draw_value(shape, base, i, step), i == len - 1);
		end
	endtask

	initial begin
		logic [CFG_BITS-1:0] w;
		int                  k;
		int                  len;
		int                  r;
		int                  change_at;
		clk = 1'b0;
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		last = 1'b0;
		result_stall = 1'b0;
		cfg_valid = 1'b0;
		window_size = swmms_pkg::WINDOW_RESET;
		calm = 0;
		sent = 0;
		cfg_writes = 0;
		mid_changes = 0;
		tracker = new();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Directed: reset window of three, full and short streams
		send_sample(32767, 0);
		send_sample(-32768, 0);
		send_sample(0, 1);
		send_sample(-1, 0);
		send_sample(1, 1);
		// Window of one, single-sample streams at the extremes
		write_window(1);
		send_sample(-32768, 1);
		send_sample(32767, 1);
		// Zero window acts as one
		write_window(0);
		send_sample(5, 0);
		send_sample(-7, 1);
		// Oversized window clamps to the maximum, stream is short
		write_window(127);
		send_sample(1, 0);
		send_sample(2, 0);
		send_sample(3, 1);
		// Grow the window mid-stream
		write_window(2);
		send_sample(10, 0);
		send_sample(-20, 0);
		send_sample(30, 0);
		send_sample(-40, 0);
		write_window(4);
		mid_changes++;
		send_sample(50, 0);
		send_sample(-60, 1);
		// Shrink the window mid-stream
		send_sample(7, 0);
		send_sample(8, 0);
		send_sample(9, 0);
		send_sample(-100, 0);
		send_sample(3, 0);
		write_window(2);
		mid_changes++;
		send_sample(1, 0);
		send_sample(-2, 1);

		// Random phases: one window setting, a few streams each
		while (sent < ITEMS) begin
			r = $urandom_range(0, 9);
			case (r)
				0: begin
					case ($urandom_range(0, 3))
						0: w = 0;
						1: w = 1;
						2: w = 64;
						default: w = 127;
					endcase
				end
				1: w = CFG_BITS'($urandom_range(65, 127));
				2, 3: w = CFG_BITS'($urandom_range(1, 64));
				default: w = CFG_BITS'($urandom_range(1, 8));
			endcase
			write_window(w);
			calm = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(2, 5)) begin
				if (sent >= ITEMS)
					break;
				k = tracker.span();
				r = $urandom_range(0, 9);
				if (r < 2)
					len = (k > 1) ? $urandom_range(1, k - 1) : 1;
				else if (r < 8)
					len = $urandom_range(k, k + 10);
				else
					len = $urandom_range(k, 3 * k + 20);
				change_at = -1;
				if (len > 1 && $urandom_range(0, 9) == 0)
					change_at = $urandom_range(1, len - 1);
				run_stream(len, change_at, CFG_BITS'($urandom_range(0, 70)));
			end
		end

		// Drain and decide
		calm = 0;
		settle();
		tracker.finish_check();
		$display("Sent %0d samples; checked %0d stream totals, %0d of them short.",
			sent, tracker.checked, tracker.shorts);
		$display("Window written %0d times, %0d of them mid-stream; %0d mismatches.",
			cfg_writes, mid_changes, tracker.fails);
		if (tracker.fails == 0)
			$display("[sliding_window_min_max_sum] OK");
		else
			$display("[sliding_window_min_max_sum] ERROR");
		$finish;
	end

endmodule
